FILE: rtl/core/mean_abs_return_after_top_volume_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean-absolute-return unit
// Implication checks on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEAN_ABS_RETURN_AFTER_TOP_VOLUME_UNIT_DEFINES_SVH
`define MEAN_ABS_RETURN_AFTER_TOP_VOLUME_UNIT_DEFINES_SVH

// same-cycle implication
`define MARV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MARV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/marv_pkg.sv
// ----------------------------------------------------------------------------
// marv_pkg
// Shared types, constants and helpers for the mean-absolute-return unit.
// ----------------------------------------------------------------------------
package marv_pkg;

   localparam int MAX_LEN_DEF   = 256;
   localparam int FRAC_BITS_DEF = 27;
   localparam logic [31:0] LN2_Q32 = 32'd2977044471;

   // nine tenths of (n-1) as ((n-1) * 9 * 0xCCCD) >> 19, exact for n up to 4096
   localparam logic [31:0] RANK_MUL   = 32'd471861;
   localparam int          RANK_SHIFT = 19;

   typedef struct packed {
      logic [31:0] price;
      logic        price_ok;
      logic [31:0] volume;
      logic        volume_ok;
   } sample_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_COUNT  = 13'b0000000000010,
      ST_RANK   = 13'b0000000000100,
      ST_SEARCH = 13'b0000000001000,
      ST_PADDR  = 13'b0000000010000,
      ST_PDATA  = 13'b0000000100000,
      ST_SQ     = 13'b0000001000000,
      ST_NORM   = 13'b0000010000000,
      ST_PACC   = 13'b0000100000000,
      ST_DIV    = 13'b0001000000000,
      ST_MHI    = 13'b0010000000000,
      ST_MLO    = 13'b0100000000000,
      ST_MFIN   = 13'b1000000000000
   } state_type;

   function automatic logic [4:0] msb_index(input logic [31:0] x);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

endpackage

FILE: rtl/core/mean_abs_return_after_top_volume_unit.sv
// ----------------------------------------------------------------------------
// mean_abs_return_after_top_volume_unit
// Mean absolute log return over the top-decile volume steps of one series.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; each is written to the
// store while it has room, and later ones only set the overflow flag. On the
// sample marked last the unit goes busy and runs its sequencer: a pass over
// the n stored samples to count valid volumes, a product on the shared
// multiplier for the rank, 32 binary-search passes for the volume threshold,
// one pass with a log per valid nonzero price on the shared multiplier, one
// divider run for the mean (SW = FRAC_BITS + 5 + clog2(MAX_LEN+1) bits) and
// two multiplies by ln 2 with a final add. With fewer than two valid
// volumes, or no pairs, it ends early with the result marked invalid. All
// steps share the single store read port, multiplier and divider. The
// result is presented with rsp_strobe for one cycle and must be taken then.
// ----------------------------------------------------------------------------
`include "mean_abs_return_after_top_volume_unit_defines.svh"

module mean_abs_return_after_top_volume_unit
   import marv_pkg::*;
#(
   parameter int MAX_LEN   = MAX_LEN_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_price,
   input  logic        req_price_valid,
   input  logic [31:0] req_volume,
   input  logic        req_volume_valid,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [31:0] rsp_mean_abs_log_return,
   output logic        rsp_result_valid,
   output logic [7:0]  rsp_pairs_used,
   output logic        rsp_overflowed
);

   localparam int AW  = $clog2(MAX_LEN);
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int LW  = 5 + FRAC_BITS;
   localparam int SW  = LW + CW;
   localparam int DVW = CW + 4;
   localparam int RW  = $clog2(FRAC_BITS + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  rank_ff, rank_in;
   logic [31:0]    lo_ff, lo_in;
   logic [31:0]    hi_ff, hi_in;
   logic [31:0]    thr_ff, thr_in;
   logic [4:0]     e_ff, e_in;
   logic [31:0]    m_ff, m_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [RW-1:0]  round_ff, round_in;
   logic           vq_ff, vq_in;
   logic           prevq_ff, prevq_in;
   logic [LW-1:0]  prevlog_ff, prevlog_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [63:0]    hiprod_ff, hiprod_in;
   logic           strobe_ff, strobe_in;
   logic [31:0]    res_ff, res_in;
   logic           rvalid_ff, rvalid_in;
   logic [7:0]     pairs_ff, pairs_in;
   logic           rovf_ff, rovf_in;

   logic           accept;
   logic           wr_en;
   sample_type     wr_data;
   sample_type     rd_data;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    prod;
   div_ctl_type    div_ctl;
   div_sts_type    div_sts;
   logic [SW-1:0]  div_num;
   logic [DVW-1:0] div_den;
   logic [SW-1:0]  quot;
   logic [32:0]    mid_wide;
   logic [31:0]    mid;
   logic           pass_done;
   logic [32:0]    sq;
   logic [LW-1:0]  cur_log;
   logic [LW-1:0]  diff;
   logic [63:0]    mean64;
   logic [64:0]    res_wide;
   logic [4:0]     e_new;

   assign accept  = start && !busy;
   assign wr_en   = accept && (count_ff < CW'(MAX_LEN));
   assign wr_data = '{price: req_price, price_ok: req_price_valid,
                      volume: req_volume, volume_ok: req_volume_valid};

   marv_mem #(.MAX_LEN(MAX_LEN)) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (wr_data),
      .rd_addr    (idx_ff[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   marv_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   marv_div #(.NW(SW), .DW(DVW)) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quot  (quot)
   );

   assign mid_wide  = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;
   assign mid       = mid_wide[31:0];
   assign pass_done = (idx_ff == count_ff) && !pend_ff;
   assign sq        = prod[63:31];
   assign cur_log   = {e_ff, frac_ff};
   assign diff      = (cur_log > prevlog_ff) ? (cur_log - prevlog_ff)
                                             : (prevlog_ff - cur_log);
   assign mean64    = 64'(quot);
   assign res_wide  = {1'b0, hiprod_ff} + 65'(prod[63:32]);
   assign e_new     = msb_index(rd_data.price);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RANK: begin
            mul_a = 32'(acc_ff - 1'b1);
            mul_b = RANK_MUL;
         end
         ST_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_MHI: begin
            mul_a = mean64[63:32];
            mul_b = LN2_Q32;
         end
         ST_MLO: begin
            mul_a = mean64[31:0];
            mul_b = LN2_Q32;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      pend_in    = 1'b0;
      acc_in     = acc_ff;
      rank_in    = rank_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      thr_in     = thr_ff;
      e_in       = e_ff;
      m_in       = m_ff;
      frac_in    = frac_ff;
      round_in   = round_ff;
      vq_in      = vq_ff;
      prevq_in   = prevq_ff;
      prevlog_in = prevlog_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      hiprod_in  = hiprod_ff;
      strobe_in  = 1'b0;
      res_in     = res_ff;
      rvalid_in  = rvalid_ff;
      pairs_in   = pairs_ff;
      rovf_in    = rovf_ff;
      div_ctl    = '{start: 1'b0};
      div_num    = '0;
      div_den    = '0;

      if (state_ff == ST_COUNT || state_ff == ST_SEARCH) begin
         if (idx_ff < count_ff) begin
            idx_in  = idx_ff + 1'b1;
            pend_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_LEN)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_COUNT;
                  idx_in   = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_COUNT: begin
            if (pend_ff && rd_data.volume_ok) begin
               acc_in = acc_ff + 1'b1;
            end
            if (pass_done) begin
               if (acc_ff < CW'(2)) begin
                  strobe_in = 1'b1;
                  res_in    = '0;
                  rvalid_in = 1'b0;
                  pairs_in  = '0;
                  rovf_in   = ovf_ff;
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_RANK;
               end
            end
         end
         ST_RANK: begin
            pend_in = !pend_ff;
            if (pend_ff) begin
               rank_in  = prod[RANK_SHIFT +: CW];
               lo_in    = '0;
               hi_in    = '1;
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (pend_ff && rd_data.volume_ok && rd_data.volume <= mid) begin
               acc_in = acc_ff + 1'b1;
            end
            if (pass_done) begin
               if ({1'b0, acc_ff} >= {1'b0, rank_ff} + 1'b1) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid + 1'b1;
               end
               idx_in = '0;
               acc_in = '0;
               if (lo_in >= hi_in) begin
                  thr_in   = lo_in;
                  prevq_in = 1'b0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_PADDR;
               end
            end
         end
         ST_PADDR: begin
            if (idx_ff == count_ff) begin
               if (cnt_ff == '0) begin
                  strobe_in = 1'b1;
                  res_in    = '0;
                  rvalid_in = 1'b0;
                  pairs_in  = '0;
                  rovf_in   = ovf_ff;
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  div_ctl  = '{start: 1'b1};
                  div_num  = sum_ff;
                  div_den  = DVW'(cnt_ff);
                  state_in = ST_DIV;
               end
            end else begin
               state_in = ST_PDATA;
            end
         end
         ST_PDATA: begin
            vq_in = rd_data.volume_ok && (rd_data.volume >= thr_ff);
            if (rd_data.price_ok && rd_data.price != '0) begin
               e_in     = e_new;
               m_in     = rd_data.price << (5'd31 - e_new);
               frac_in  = '0;
               round_in = RW'(FRAC_BITS);
               state_in = ST_SQ;
            end else begin
               prevq_in = 1'b0;
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PADDR;
            end
         end
         ST_SQ: begin
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (sq[32]) begin
               m_in    = sq[32:1];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = sq[31:0];
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            round_in = round_ff - 1'b1;
            state_in = (round_ff == RW'(1)) ? ST_PACC : ST_SQ;
         end
         ST_PACC: begin
            if (prevq_ff) begin
               sum_in = sum_ff + SW'(diff);
               cnt_in = cnt_ff + 1'b1;
            end
            prevlog_in = cur_log;
            prevq_in   = vq_ff;
            idx_in     = idx_ff + 1'b1;
            state_in   = ST_PADDR;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_MHI;
            end
         end
         ST_MHI: begin
            state_in = ST_MLO;
         end
         ST_MLO: begin
            hiprod_in = prod;
            state_in  = ST_MFIN;
         end
         ST_MFIN: begin
            strobe_in = 1'b1;
            res_in    = (res_wide > 65'h0_FFFF_FFFF) ? '1 : res_wide[31:0];
            rvalid_in = 1'b1;
            pairs_in  = (cnt_ff > CW'(255)) ? 8'hFF : 8'(cnt_ff);
            rovf_in   = ovf_ff;
            count_in  = '0;
            ovf_in    = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      rank_ff    <= rank_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      thr_ff     <= thr_in;
      e_ff       <= e_in;
      m_ff       <= m_in;
      frac_ff    <= frac_in;
      round_ff   <= round_in;
      vq_ff      <= vq_in;
      prevq_ff   <= prevq_in;
      prevlog_ff <= prevlog_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      hiprod_ff  <= hiprod_in;
      res_ff     <= res_in;
      rvalid_ff  <= rvalid_in;
      pairs_ff   <= pairs_in;
      rovf_ff    <= rovf_in;
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign rsp_strobe              = strobe_ff;
   assign rsp_mean_abs_log_return = res_ff;
   assign rsp_result_valid        = rvalid_ff;
   assign rsp_pairs_used          = pairs_ff;
   assign rsp_overflowed          = rovf_ff;

   `MARV_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_strobe && !rsp_result_valid,
      rsp_mean_abs_log_return == '0 && rsp_pairs_used == '0)
   `MARV_ASSERT_NOW(a_result_idle, clock, reset, rsp_strobe, !busy && count_ff == '0)
   `MARV_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `MARV_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_LEN))

endmodule

FILE: rtl/core/marv_mem.sv
// ----------------------------------------------------------------------------
// marv_mem
// Sample store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module marv_mem
   import marv_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF,
   localparam int AW = $clog2(MAX_LEN)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  sample_type       wr_data,
   input  logic [AW-1:0]    rd_addr,
   output sample_type       rd_data_ff
);

   sample_type store_mem [MAX_LEN];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

endmodule

FILE: rtl/core/marv_mul.sv
// ----------------------------------------------------------------------------
// marv_mul
// Shared 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module marv_mul
   import marv_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

endmodule

FILE: rtl/core/marv_div.sv
// ----------------------------------------------------------------------------
// marv_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module marv_div
   import marv_pkg::*;
#(
   parameter int NW = 48,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  div_ctl_type   ctl,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output div_sts_type   sts,
   output logic [NW-1:0] quot
);

   localparam int KW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [KW-1:0] k_ff, k_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DW-1:0], q_ff[NW-1]};
      if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         k_in = k_ff - 1'b1;
         if (k_ff == KW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         k_in    = KW'(NW);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      k_ff <= k_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = q_ff;

endmodule

FILE: verif/tb_mean_abs_return_after_top_volume_unit.sv
// ----------------------------------------------------------------------------
// Testbench for mean_abs_return_after_top_volume_unit
// Drives series of (price, volume) samples in bursts with random gaps.
// Predicts the top-decile mean absolute log return of each series, or all
// zeros for typed directed rows, and checks each result field by field.
// Directed rows first, then random series; a few long ones may overflow.
// ----------------------------------------------------------------------------
module tb_mean_abs_return_after_top_volume_unit;
   import marv_pkg::*;

   localparam int DEPTH = MAX_LEN_DEF;
   localparam int FRAC  = FRAC_BITS_DEF;

   typedef struct {
      logic [31:0] mean;
      logic        rv;
      logic [7:0]  pairs;
      logic        ovf;
   } series_result_type;

   typedef struct {
      logic [31:0] price;
      logic        pv;
      logic [31:0] vol;
      logic        vv;
      logic        last;
      bit          typed;
      series_result_type res;
   } sample_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_price;
   logic        req_price_valid;
   logic [31:0] req_volume;
   logic        req_volume_valid;
   logic        req_last;
   logic        rsp_strobe;
   logic [31:0] rsp_mean_abs_log_return;
   logic        rsp_result_valid;
   logic [7:0]  rsp_pairs_used;
   logic        rsp_overflowed;

   logic [31:0] price_mem [DEPTH];
   bit          price_ok_mem [DEPTH];
   logic [31:0] volume_mem [DEPTH];
   bit          volume_ok_mem [DEPTH];
   int          stored_samples;
   bit          series_overflow;

   series_result_type pending_results[$];
   int errors;

   mean_abs_return_after_top_volume_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_price(req_price), .req_price_valid(req_price_valid),
      .req_volume(req_volume), .req_volume_valid(req_volume_valid),
      .req_last(req_last), .rsp_strobe(rsp_strobe),
      .rsp_mean_abs_log_return(rsp_mean_abs_log_return),
      .rsp_result_valid(rsp_result_valid), .rsp_pairs_used(rsp_pairs_used),
      .rsp_overflowed(rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[mean_abs_return_after_top_volume_unit] ERROR");
      $finish;
   end

   function automatic logic [63:0] log2_fixed(input logic [31:0] x);
      int          e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 31;
      frac = 0;
      while (e > 0 && !x[e]) e--;
      m = 64'(x) << (31 - e);
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << FRAC) | frac;
   endfunction

   function automatic int volumes_at_or_below(input logic [31:0] limit);
      int c;
      c = 0;
      for (int t = 0; t < stored_samples; t++)
         if (volume_ok_mem[t] && volume_mem[t] <= limit) c++;
      return c;
   endfunction

   function automatic series_result_type close_series();
      series_result_type r;
      int          n, rank, cnt;
      logic [63:0] lo, hi, mid, sum, a, b, mean, res;
      r = '{0, 0, 0, series_overflow};
      n = 0;
      cnt = 0;
      sum = 0;
      for (int t = 0; t < stored_samples; t++)
         if (volume_ok_mem[t]) n++;
      if (n < 2) return r;
      rank = (9 * (n - 1)) / 10;
      lo = 0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (volumes_at_or_below(mid[31:0]) >= rank + 1) hi = mid;
         else lo = mid + 1;
      end
      for (int t = 0; t + 1 < stored_samples; t++) begin
         if (!volume_ok_mem[t] || volume_mem[t] < lo) continue;
         if (!price_ok_mem[t] || price_mem[t] == 0) continue;
         if (!price_ok_mem[t+1] || price_mem[t+1] == 0) continue;
         a = log2_fixed(price_mem[t]);
         b = log2_fixed(price_mem[t+1]);
         sum += (a > b) ? a - b : b - a;
         cnt++;
      end
      if (cnt == 0) return r;
      mean = sum / cnt;
      res = (mean >> 32) * LN2_Q32 + (((mean & 64'hFFFF_FFFF) * LN2_Q32) >> 32);
      r.mean = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
      r.rv = 1'b1;
      r.pairs = (cnt > 255) ? 8'd255 : 8'(cnt);
      return r;
   endfunction

   // returns 1 and the series result when the sample closes a series
   function automatic bit take_sample(input sample_row_type s,
                                      output series_result_type r);
      if (stored_samples < DEPTH) begin
         price_mem[stored_samples] = s.price;
         price_ok_mem[stored_samples] = s.pv;
         volume_mem[stored_samples] = s.vol;
         volume_ok_mem[stored_samples] = s.vv;
         stored_samples++;
      end else begin
         series_overflow = 1'b1;
      end
      if (!s.last) return 0;
      r = close_series();
      stored_samples = 0;
      series_overflow = 1'b0;
      return 1;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transaction", 32'(rsp_strobe), 32'd0);
         end else begin
            series_result_type w;
            w = pending_results.pop_front();
            if (rsp_mean_abs_log_return !== w.mean)
               report_mismatch("mean_abs_log_return", rsp_mean_abs_log_return, w.mean);
            if (rsp_result_valid !== w.rv)
               report_mismatch("result_valid", 32'(rsp_result_valid), 32'(w.rv));
            if (rsp_pairs_used !== w.pairs)
               report_mismatch("pairs_used", 32'(rsp_pairs_used), 32'(w.pairs));
            if (rsp_overflowed !== w.ovf)
               report_mismatch("overflowed", 32'(rsp_overflowed), 32'(w.ovf));
         end
      end
   end

   int burst_left;

   task automatic send_sample(input sample_row_type s);
      series_result_type r;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      start <= 1'b1;
      req_price <= s.price;
      req_price_valid <= s.pv;
      req_volume <= s.vol;
      req_volume_valid <= s.vv;
      req_last <= s.last;
      do @(posedge clock); while (busy);
      burst_left--;
      if (take_sample(s, r)) begin
         if (s.typed) r = s.res;
         pending_results.insert(pending_results.size(), r);
      end
   endtask

   function automatic sample_row_type row(input logic [31:0] p, input logic pv,
                                          input logic [31:0] v, input logic vv,
                                          input logic last, input bit typed);
      sample_row_type s;
      s.price = p;
      s.pv = pv;
      s.vol = v;
      s.vv = vv;
      s.last = last;
      s.typed = typed;
      s.res = '{0, 0, 0, 0};
      return s;
   endfunction

   sample_row_type directed_rows[$];

   initial begin
      int          len, mode, items;
      logic [31:0] base_price, base_vol;
      sample_row_type s;
      errors = 0;
      stored_samples = 0;
      series_overflow = 0;
      burst_left = 0;
      start = 0;
      req_price = 0;
      req_price_valid = 0;
      req_volume = 0;
      req_volume_valid = 0;
      req_last = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      directed_rows = '{
         row(100, 1, 5, 1, 1, 1),
         row(0, 1, 7, 1, 0, 0), row(50, 1, 7, 1, 1, 1),
         row(10, 1, 1, 0, 0, 0), row(20, 1, 2, 0, 1, 1),
         row(7, 0, 3, 1, 0, 0), row(9, 1, 3, 1, 1, 1),
         row(1, 1, 32'hFFFF_FFFF, 1, 0, 0), row(32'hFFFF_FFFF, 1, 0, 1, 0, 0),
         row(1, 1, 32'hFFFF_FFFF, 1, 1, 0),
         row(1000, 1, 10, 1, 0, 0), row(2000, 1, 10, 1, 0, 0),
         row(1000, 1, 10, 1, 1, 0),
         row(32'hAAAA_AAAA, 1, 32'h5555_5555, 1, 0, 0),
         row(32'h5555_5555, 1, 32'hAAAA_AAAA, 1, 1, 0)
      };
      foreach (directed_rows[i]) send_sample(directed_rows[i]);

      items = 0;
      while (items < 1600) begin
         mode = $urandom_range(0, 99);
         if (mode < 3) len = $urandom_range(250, 300);
         else if (mode < 8) len = 1;
         else len = $urandom_range(2, 24);
         base_price = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 100000);
         base_vol = $urandom_range(0, 1000);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) s.price = $urandom;
            else if ($urandom_range(0, 30) == 0) s.price = 0;
            else s.price = base_price + $urandom_range(0, base_price / 8 + 1);
            s.pv = ($urandom_range(0, 12) != 0);
            if (mode < 1) s.vol = base_vol;
            else if ($urandom_range(0, 6) == 0) s.vol = $urandom;
            else s.vol = base_vol + $urandom_range(0, 50);
            s.vv = ($urandom_range(0, 12) != 0);
            s.last = (k == len - 1);
            s.typed = 0;
            send_sample(s);
            items++;
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[mean_abs_return_after_top_volume_unit] OK");
      else
         $display("[mean_abs_return_after_top_volume_unit] ERROR");
      $finish;
   end
endmodule

FILE: mean_abs_return_after_top_volume_unit.f
+incdir+rtl/core
rtl/core/marv_pkg.sv
rtl/core/marv_mem.sv
rtl/core/marv_mul.sv
rtl/core/marv_div.sv
rtl/core/mean_abs_return_after_top_volume_unit.sv
verif/tb_mean_abs_return_after_top_volume_unit.sv
